// ===== rtl/anagram_multiset_matcher_unit_macros.svh =====
// assertion macros shared by the matcher checker
// no dependencies; the including module must have clock and reset in scope
`ifndef ANAGRAM_MULTISET_MATCHER_UNIT_MACROS_SVH
`define ANAGRAM_MULTISET_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AMM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("matcher check failed");

// next-cycle implication, checked outside reset
`define AMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error("matcher check failed");

`endif

// ===== rtl/amm_pkg.sv =====
// shared types and constants for the anagram multiset matcher
// no dependencies
package amm_pkg;

   // symbol alphabet
   localparam int SYM_W     = 8;
   localparam int SYM_COUNT = 256;

   // width of the reported candidate length
   localparam int LEN_OUT_W = 8;

   // word tag of an input symbol
   typedef enum logic {
      MODE_PATTERN   = 1'b0,
      MODE_CANDIDATE = 1'b1
   } mode_type;

   // comparison kind held in the control register
   typedef enum logic {
      KIND_EXACT  = 1'b0,
      KIND_SUBSET = 1'b1
   } kind_type;

   // control of one histogram: lookup issue, clear and update
   typedef struct packed {
      logic             rd_en;
      logic [SYM_W-1:0] rd_addr;
      logic             clear;
      logic             wr_en;
      logic [SYM_W-1:0] sym;
   } hist_ctl_type;

endpackage

// ===== rtl/amm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module amm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/amm_hist.sv =====
// one symbol histogram: count ram, per-entry valid bits, write forwarding
// depends on amm_pkg and amm_ram
module amm_hist #(
   parameter int CNT_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  amm_pkg::hist_ctl_type ctl,
   input  logic [CNT_W-1:0]     wr_data,
   output logic [CNT_W-1:0]     count
);

   import amm_pkg::*;

   logic [SYM_COUNT-1:0] valid_ff;
   logic [SYM_COUNT-1:0] valid_in;
   logic                 fwd_hit_ff;
   logic                 fwd_hit_in;
   logic [CNT_W-1:0]     fwd_data_ff;
   logic [CNT_W-1:0]     rd_data;

   amm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (SYM_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.sym),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   // valid bits: clear drops all, a write marks its entry
   always_comb begin
      valid_in = ctl.clear ? '0 : valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.sym] = 1'b1;
      end
   end

   // a write landing in the cycle of a read is forwarded to that read
   assign fwd_hit_in = ctl.wr_en && (ctl.sym == ctl.rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   // count of the symbol now in the compute stage
   assign count = valid_ff[ctl.sym] ? (fwd_hit_ff ? fwd_data_ff : rd_data) : '0;

endmodule

// ===== rtl/anagram_multiset_matcher_unit.sv =====
// top level of the anagram multiset matcher
// depends on amm_pkg and amm_hist (which holds amm_ram)
//
//   channel   dir   handshake               word
//   req_      in    req_valid / req_stall   mode, symbol, last
//   rsp_      out   rsp_valid / rsp_stall   is_match, too_long, candidate_length
//   csr_      in    csr_valid / csr_ready   match_kind
//
// one symbol per cycle unless stalled; a last candidate symbol's result word reaches
// rsp_ via the compute stage input and result registers. histogram read-modify-write:
// ram read at accept, update and write back in the compute stage, with write forwarding
// between neighbors. reset clears the histograms at once through per-entry valid bits,
// no sweep. req_stall rises only when a result waits in the output register under
// rsp_stall and the compute stage holds another last candidate symbol.
module anagram_multiset_matcher_unit #(
   parameter int MAX_WORD_LEN = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [amm_pkg::SYM_W-1:0]     req_symbol,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_match,
   output logic                          rsp_too_long,
   output logic [amm_pkg::LEN_OUT_W-1:0] rsp_candidate_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_match_kind
);

   import amm_pkg::*;

   localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
   localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_WORD_LEN);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // compute stage input register
   logic             s1_valid_ff;
   mode_type         s1_mode_ff;
   logic [SYM_W-1:0] s1_sym_ff;
   logic             s1_last_ff;

   // matcher state
   kind_type         kind_ff;
   logic [CNT_W-1:0] plen_ff, plen_in;
   logic [CNT_W-1:0] clen_ff, clen_in;
   logic [CNT_W-1:0] def_ff, def_in;
   logic             pat_done_ff, pat_done_in;
   logic             povf_ff, povf_in;
   logic             lovf_ff, lovf_in;
   logic             in_cand_ff, in_cand_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_match_ff, rsp_match_in;
   logic                 rsp_long_ff, rsp_long_in;
   logic [LEN_OUT_W-1:0] rsp_len_ff;

   // histogram interface
   hist_ctl_type     ref_ctl, cand_ctl;
   logic [CNT_W-1:0] ref_wdata, cand_wdata;
   logic [CNT_W-1:0] ref_cnt, cand_cnt;

   // working values of the compute stage
   logic             start;
   logic [CNT_W-1:0] plen_eff, clen_eff, def_eff, ref_eff, cand_eff;
   logic             povf_eff, lovf_eff;

   // handshake
   logic s1_result, out_free, s1_go, req_take;

   assign s1_result = s1_valid_ff && (s1_mode_ff == MODE_CANDIDATE) && s1_last_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_result || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   amm_hist #(.CNT_W(CNT_W)) u_ref_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ref_ctl),
      .wr_data (ref_wdata),
      .count   (ref_cnt)
   );

   amm_hist #(.CNT_W(CNT_W)) u_cand_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cand_ctl),
      .wr_data (cand_wdata),
      .count   (cand_cnt)
   );

   // compute stage: one histogram update and the verdict
   always_comb begin
      plen_in      = plen_ff;
      clen_in      = clen_ff;
      def_in       = def_ff;
      pat_done_in  = pat_done_ff;
      povf_in      = povf_ff;
      lovf_in      = lovf_ff;
      in_cand_in   = in_cand_ff;
      ref_ctl      = '{rd_en: req_take, rd_addr: req_symbol, clear: 1'b0, wr_en: 1'b0,
                       sym: s1_sym_ff};
      cand_ctl     = '{rd_en: req_take, rd_addr: req_symbol, clear: 1'b0, wr_en: 1'b0,
                       sym: s1_sym_ff};
      ref_wdata    = '0;
      cand_wdata   = '0;
      rsp_match_in = 1'b0;
      rsp_long_in  = 1'b0;
      start        = 1'b0;
      plen_eff     = plen_ff;
      clen_eff     = clen_ff;
      def_eff      = def_ff;
      ref_eff      = ref_cnt;
      cand_eff     = cand_cnt;
      povf_eff     = povf_ff;
      lovf_eff     = lovf_ff;
      if (s1_go) begin
         unique case (s1_mode_ff)
            MODE_PATTERN: begin
               // a pattern symbol after a finished pattern starts a new one
               in_cand_in    = 1'b0;
               start         = pat_done_ff;
               plen_eff      = start ? '0 : plen_ff;
               povf_eff      = start ? 1'b0 : povf_ff;
               ref_eff       = start ? '0 : ref_cnt;
               ref_ctl.clear = start;
               povf_in       = povf_eff;
               plen_in       = plen_eff;
               if (plen_eff >= MAX_LEN) begin
                  povf_in = 1'b1;
               end else begin
                  ref_ctl.wr_en = 1'b1;
                  ref_wdata     = ref_eff + CNT_ONE;
                  plen_in       = plen_eff + CNT_ONE;
               end
               pat_done_in = s1_last_ff;
            end
            MODE_CANDIDATE: begin
               // first symbol of a candidate restarts its histogram and deficit
               pat_done_in    = 1'b1;
               start          = !in_cand_ff;
               clen_eff       = start ? '0 : clen_ff;
               def_eff        = start ? plen_ff : def_ff;
               lovf_eff       = start ? 1'b0 : lovf_ff;
               cand_eff       = start ? '0 : cand_cnt;
               cand_ctl.clear = start;
               clen_in        = clen_eff;
               def_in         = def_eff;
               lovf_in        = lovf_eff;
               if (clen_eff >= MAX_LEN) begin
                  lovf_in = 1'b1;
               end else begin
                  if ((cand_eff < ref_cnt) && (def_eff != '0)) begin
                     def_in = def_eff - CNT_ONE;
                  end
                  cand_ctl.wr_en = 1'b1;
                  cand_wdata     = cand_eff + CNT_ONE;
                  clen_in        = clen_eff + CNT_ONE;
               end
               rsp_long_in  = povf_ff || lovf_in;
               rsp_match_in = !rsp_long_in && (def_in == '0) &&
                              ((kind_ff == KIND_SUBSET) || (clen_in == plen_ff));
               in_cand_in   = !s1_last_ff;
            end
         endcase
      end
   end

   // compute stage input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= mode_type'(req_mode);
         s1_sym_ff  <= req_symbol;
         s1_last_ff <= req_last;
      end
   end

   // control register and matcher state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= KIND_EXACT;
         plen_ff     <= '0;
         clen_ff     <= '0;
         def_ff      <= '0;
         pat_done_ff <= 1'b0;
         povf_ff     <= 1'b0;
         lovf_ff     <= 1'b0;
         in_cand_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            kind_ff <= kind_type'(csr_match_kind);
         end
         plen_ff     <= plen_in;
         clen_ff     <= clen_in;
         def_ff      <= def_in;
         pat_done_ff <= pat_done_in;
         povf_ff     <= povf_in;
         lovf_ff     <= lovf_in;
         in_cand_ff  <= in_cand_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_result) begin
         rsp_match_ff <= rsp_match_in;
         rsp_long_ff  <= rsp_long_in;
         rsp_len_ff   <= LEN_OUT_W'(clen_in);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_match         = rsp_match_ff;
   assign rsp_too_long         = rsp_long_ff;
   assign rsp_candidate_length = rsp_len_ff;

endmodule

// ===== rtl/amm_checker.sv =====
// port-level checks on the matcher, bound to the top level
// depends on amm_pkg and anagram_multiset_matcher_unit_macros.svh
`include "anagram_multiset_matcher_unit_macros.svh"

module amm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_mode,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_is_match,
   input logic                          rsp_too_long,
   input logic [amm_pkg::LEN_OUT_W-1:0] rsp_candidate_length
);

   import amm_pkg::*;

   logic [LEN_OUT_W+1:0] rsp_word;
   logic                 cand_last_take;

   assign rsp_word       = {rsp_is_match, rsp_too_long, rsp_candidate_length};
   assign cand_last_take = req_valid && !req_stall && (req_mode == MODE_CANDIDATE) &&
                           req_last;

   // a stalled result word stays put
   `AMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // an overlong word never matches
   `AMM_ASSERT_IMPL(a_long_no_match, rsp_valid, !(rsp_is_match && rsp_too_long))

   // a finished candidate shows its result unless the output is held
   `AMM_ASSERT_NEXT(a_cand_result, cand_last_take, ((rsp_valid && rsp_stall) or (##1 rsp_valid)))

endmodule

bind anagram_multiset_matcher_unit amm_checker u_amm_checker (.*);

// ===== verif/tb_anagram_multiset_matcher_unit.sv =====
// self-checking testbench for anagram_multiset_matcher_unit: directed table, then random strings
// depends on amm_pkg and the matcher rtl; predicts untyped results with its own histogram model
`timescale 1ns / 100ps

module tb_anagram_multiset_matcher_unit;
   import amm_pkg::*;

   localparam int WORD_BOUND  = 255;
   localparam int HOLD_CYCLES = 90;

   typedef logic [SYM_W-1:0] sym_queue_type [$];

   typedef struct packed {
      logic                 is_match;
      logic                 too_long;
      logic [LEN_OUT_W-1:0] length;
   } verdict_type;

   typedef enum logic {
      ROW_SYMBOL = 1'b0,
      ROW_KIND   = 1'b1
   } row_op_type;

   typedef struct packed {
      row_op_type       op;
      kind_type         kind;
      mode_type         mode;
      logic [SYM_W-1:0] sym;
      logic             last;
      logic             typed;
      verdict_type      want;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_mode;
   logic [SYM_W-1:0]     req_symbol;
   logic                 req_last;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_is_match;
   logic                 rsp_too_long;
   logic [LEN_OUT_W-1:0] rsp_candidate_length;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_match_kind;

   // histogram model state
   logic [7:0]       ref_hist [SYM_COUNT];
   logic [7:0]       cand_hist [SYM_COUNT];
   logic [7:0]       pat_len;
   logic [7:0]       cand_len;
   logic [7:0]       deficit;
   logic             pat_done;
   logic             pat_over;
   logic             cand_over;
   logic             cand_open;
   kind_type         kind_now;

   verdict_type      pending_verdicts [$];
   int               mismatches = 0;
   int               sent = 0;

   // stimulus control shared with the stall process
   bit               tx_calm = 1'b0;
   bit               rx_calm = 1'b0;
   bit               hold_pending = 1'b0;
   bit               narrow = 1'b0;
   logic [SYM_W-1:0] alphabet [4];
   sym_queue_type    pattern_q;

   // directed rows: empty pattern, byte extremes, abandoned candidate, early close, both kinds
   script_row_type script [25] = '{
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h61, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd1}},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'hFF, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'h41, 1'b1, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'hFF, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h41, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd3}},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd3}},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h41, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'h80, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'h7F, 1'b1, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h7F, 1'b1, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_PATTERN,   8'h55, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'h55, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd1}},
      '{ROW_KIND,   KIND_SUBSET, MODE_PATTERN,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_CANDIDATE, 8'h55, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_CANDIDATE, 8'h01, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd2}},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_CANDIDATE, 8'h01, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd1}},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_PATTERN,   8'hAA, 1'b1, 1'b0, '0},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_CANDIDATE, 8'hAA, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_SUBSET, MODE_CANDIDATE, 8'hAA, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd2}},
      '{ROW_KIND,   KIND_EXACT,  MODE_PATTERN,   8'h00, 1'b0, 1'b0, '0},
      '{ROW_SYMBOL, KIND_EXACT,  MODE_CANDIDATE, 8'hAA, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd1}}
   };

   anagram_multiset_matcher_unit #(
      .MAX_WORD_LEN(WORD_BOUND)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_symbol          (req_symbol),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_is_match        (rsp_is_match),
      .rsp_too_long        (rsp_too_long),
      .rsp_candidate_length(rsp_candidate_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_match_kind      (csr_match_kind)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("anagram_multiset_matcher_unit verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // one accepted symbol through the histogram model; returns 1 when a result is due
   function automatic logic tally_symbol(input mode_type m, input logic [SYM_W-1:0] s,
                                         input logic l, output verdict_type v);
      logic over;
      v = '0;
      if (m == MODE_PATTERN) begin
         cand_open = 1'b0;
         // a pattern symbol after a closed pattern starts a new one
         if (pat_done) begin
            foreach (ref_hist[i]) ref_hist[i] = '0;
            pat_len  = '0;
            pat_over = 1'b0;
            pat_done = 1'b0;
         end
         if (pat_len >= WORD_BOUND) begin
            pat_over = 1'b1;
         end else begin
            ref_hist[s]++;
            pat_len++;
         end
         if (l) pat_done = 1'b1;
         return 1'b0;
      end
      // any candidate symbol closes the pattern as it stands
      pat_done = 1'b1;
      if (!cand_open) begin
         foreach (cand_hist[i]) cand_hist[i] = '0;
         cand_len  = '0;
         deficit   = pat_len;
         cand_over = 1'b0;
         cand_open = 1'b1;
      end
      if (cand_len >= WORD_BOUND) begin
         cand_over = 1'b1;
      end else begin
         if (cand_hist[s] < ref_hist[s] && deficit != 0) deficit--;
         cand_hist[s]++;
         cand_len++;
      end
      if (!l) return 1'b0;
      over       = pat_over || cand_over;
      v.too_long = over;
      v.is_match = !over && deficit == 0 &&
                   !(kind_now == KIND_EXACT && cand_len != pat_len);
      v.length   = cand_len;
      cand_open  = 1'b0;
      return 1'b1;
   endfunction

   // offer one word on the request channel; returns at the falling edge after acceptance
   task automatic offer(input mode_type m, input logic [SYM_W-1:0] s, input logic l,
                        input logic typed, input verdict_type want);
      verdict_type got;
      while (!tx_calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= m;
      req_symbol <= s;
      req_last   <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (tally_symbol(m, s, l, got))
         pending_verdicts.insert(pending_verdicts.size(), typed ? want : got);
      @(negedge clock);
   endtask

   task automatic send_symbol(input mode_type m, input logic [SYM_W-1:0] s, input logic l);
      offer(m, s, l, 1'b0, '0);
   endtask

   task automatic send_string(input mode_type m, input sym_queue_type w, input logic close);
      foreach (w[i]) send_symbol(m, w[i], close && i == w.size() - 1);
   endtask

   // drain all results, then allow the pipeline to empty of symbols that give none
   task automatic await_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_kind(input kind_type k);
      csr_valid      <= 1'b1;
      csr_match_kind <= k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      kind_now = k;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic sym_queue_type mixed(input sym_queue_type q);
      logic [SYM_W-1:0] t;
      int               j;
      for (int i = q.size() - 1; i > 0; i--) begin
         j    = $urandom_range(i);
         t    = q[i];
         q[i] = q[j];
         q[j] = t;
      end
      return q;
   endfunction

   // a small alphabet makes repeated bytes and real matches likely
   function automatic logic [SYM_W-1:0] pick_symbol();
      return narrow ? alphabet[$urandom_range(3)] : SYM_W'($urandom_range(255));
   endfunction

   function automatic sym_queue_type fresh_string(input int len);
      sym_queue_type w;
      repeat (len) w.insert(w.size(), pick_symbol());
      return w;
   endfunction

   task automatic new_pattern(input int len);
      narrow = $urandom_range(99) < 70;
      foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom_range(255));
      pattern_q = fresh_string(len);
      send_string(MODE_PATTERN, pattern_q, 1'b1);
   endtask

   // mostly well-formed candidates against the current pattern, some broken sequences
   task automatic run_phase(input kind_type k, input int quota, input bit calm, input bit press);
      int            stop;
      int            pick;
      sym_queue_type w;
      await_idle();
      write_kind(k);
      tx_calm = calm;
      rx_calm = calm;
      stop    = sent + quota;
      // receiver holds off while one-symbol candidates keep coming
      if (press) begin
         tx_calm      = 1'b1;
         hold_pending = 1'b1;
         repeat (40) send_symbol(MODE_CANDIDATE, pick_symbol(), 1'b1);
         tx_calm = calm;
      end
      new_pattern($urandom_range(1, 8));
      while (sent < stop) begin
         pick = $urandom_range(99);
         w    = mixed(pattern_q);
         if (pick < 12) begin
            new_pattern($urandom_range(1, 8));
         end else if (pick < 50) begin
            send_string(MODE_CANDIDATE, w, 1'b1);
         end else if (pick < 65) begin
            // pattern plus extra bytes
            repeat ($urandom_range(1, 3)) w.insert(w.size(), pick_symbol());
            send_string(MODE_CANDIDATE, mixed(w), 1'b1);
         end else if (pick < 78) begin
            // near miss: one byte dropped or replaced
            if (w.size() > 1 && $urandom_range(1)) w.delete($urandom_range(w.size() - 1));
            else w[$urandom_range(w.size() - 1)] = pick_symbol();
            send_string(MODE_CANDIDATE, w, 1'b1);
         end else if (pick < 86) begin
            send_string(MODE_CANDIDATE, fresh_string($urandom_range(1, 8)), 1'b1);
         end else if (pick < 93) begin
            // candidate cut short by a new pattern
            send_string(MODE_CANDIDATE, w, 1'b0);
            new_pattern($urandom_range(1, 8));
         end else begin
            // pattern left open, closed by the candidate
            pattern_q = fresh_string($urandom_range(1, 6));
            send_string(MODE_PATTERN, pattern_q, 1'b0);
            send_string(MODE_CANDIDATE, mixed(pattern_q), 1'b1);
         end
      end
   endtask

   // receiver stall: random, calm, or one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            rsp_stall <= !rx_calm && ($urandom_range(99) < 16);
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result with no expectation pending");
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_is_match !== want.is_match)
               report_mismatch($sformatf("is_match %b, expected %b",
                                         rsp_is_match, want.is_match));
            if (rsp_too_long !== want.too_long)
               report_mismatch($sformatf("too_long %b, expected %b",
                                         rsp_too_long, want.too_long));
            if (rsp_candidate_length !== want.length)
               report_mismatch($sformatf("candidate_length %0d, expected %0d",
                                         rsp_candidate_length, want.length));
         end
      end
   end

   initial begin
      sym_queue_type w;
      int            guard;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_PATTERN;
      req_symbol     = '0;
      req_last       = 1'b0;
      csr_valid      = 1'b0;
      csr_match_kind = KIND_EXACT;
      foreach (ref_hist[i]) ref_hist[i] = '0;
      foreach (cand_hist[i]) cand_hist[i] = '0;
      pat_len   = '0;
      cand_len  = '0;
      deficit   = '0;
      pat_done  = 1'b0;
      pat_over  = 1'b0;
      cand_over = 1'b0;
      cand_open = 1'b0;
      kind_now  = KIND_EXACT;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (script[r]) begin
         if (script[r].op == ROW_KIND) begin
            await_idle();
            write_kind(script[r].kind);
         end else begin
            offer(script[r].mode, script[r].sym, script[r].last, script[r].typed,
                  script[r].want);
         end
      end

      run_phase(KIND_EXACT, 90, 1'b0, 1'b0);
      run_phase(KIND_SUBSET, 90, 1'b1, 1'b0);
      run_phase(KIND_SUBSET, 60, 1'b0, 1'b1);

      // strings at and beyond the length bound
      await_idle();
      write_kind(KIND_EXACT);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      new_pattern(WORD_BOUND);
      send_string(MODE_CANDIDATE, mixed(pattern_q), 1'b1);
      w = mixed(pattern_q);
      w.insert(w.size(), pick_symbol());
      w.insert(w.size(), pick_symbol());
      send_string(MODE_CANDIDATE, w, 1'b1);
      new_pattern(WORD_BOUND + 3);
      send_string(MODE_CANDIDATE, fresh_string(3), 1'b1);

      run_phase(KIND_EXACT, 90, 1'b0, 1'b0);
      run_phase(kind_type'($urandom_range(1)), 90, 1'b0, 1'b0);
      run_phase(KIND_SUBSET, 80, 1'b0, 1'b0);

      // drain with a bound, then idle before the verdict
      req_valid <= 1'b0;
      for (guard = 0; guard < 5000 && pending_verdicts.size() != 0; guard++)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (pending_verdicts.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_verdicts.size()));
      if (mismatches == 0)
         $display("anagram_multiset_matcher_unit verification clean");
      else
         $display("anagram_multiset_matcher_unit verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/amm_pkg.sv
rtl/amm_ram.sv
rtl/amm_hist.sv
rtl/anagram_multiset_matcher_unit.sv
rtl/amm_checker.sv
verif/tb_anagram_multiset_matcher_unit.sv
